### hdl/mfbps_pkg.sv
// Shared types and constants of the page-mode frame buffer scanout.
package mfbps_pkg;

  typedef enum logic [1:0] {
    ACT_SET_POINT   = 2'd0,
    ACT_CLEAR_POINT = 2'd1,
    ACT_CLEAR_ALL   = 2'd2,
    ACT_REFRESH     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic       is_hdr;
    logic       is_last;
    logic [7:0] hdr_byte;
  } scan_t;

  localparam logic [7:0] CmdPageBase = 8'hB0;
  localparam logic [7:0] CmdColLow   = 8'h00;
  localparam logic [7:0] CmdColHigh  = 8'h10;
  localparam int         HdrLen      = 3;

endpackage

### hdl/mfbps_in_if.sv
// Input channel: pixel actions and refresh steps.
interface mfbps_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [6:0] x_pos;
  logic [5:0] y_pos;

  modport source (output valid, output action, output x_pos, output y_pos, input ready);
  modport sink (input valid, input action, input x_pos, input y_pos, output ready);
endinterface

### hdl/mfbps_out_if.sv
// Output channel: scanout bytes toward the panel.
interface mfbps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       frame_end;

  modport source (output valid, output out_byte, output is_data, output frame_end,
                  input ready);
  modport sink (input valid, input out_byte, input is_data, input frame_end, output ready);
endinterface

### hdl/mfbps_ram.sv
// Frame store memory with one write port and one registered read port.
module mfbps_ram #(
  parameter int Depth = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/mfbps_scan.sv
// Scan sequencer: page and step counters, command bytes and store address.
module mfbps_scan #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8,
  parameter int AW      = 10,
  parameter int PW      = 3,
  parameter int SW      = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  output mfbps_pkg::scan_t    scan_o,
  output logic [AW-1:0]       addr_o
);

  localparam logic [SW-1:0] PosLast  = SW'(COLUMNS + mfbps_pkg::HdrLen - 1);
  localparam logic [PW-1:0] PageLast = PW'(PAGES - 1);
  localparam logic [SW-1:0] HdrLenW  = SW'(mfbps_pkg::HdrLen);

  logic [SW-1:0] pos_q, pos_d;
  logic [PW-1:0] page_q, page_d;
  logic [SW-1:0] col;

  always_comb begin
    col    = pos_q - HdrLenW;
    addr_o = AW'(32'(page_q) * COLUMNS + 32'(col));

    scan_o.is_hdr  = pos_q < HdrLenW;
    scan_o.is_last = (pos_q == PosLast) && (page_q == PageLast);
    priority if (pos_q == SW'(0)) begin
      scan_o.hdr_byte = mfbps_pkg::CmdPageBase + 8'(page_q);
    end else if (pos_q == SW'(1)) begin
      scan_o.hdr_byte = mfbps_pkg::CmdColLow;
    end else begin
      scan_o.hdr_byte = mfbps_pkg::CmdColHigh;
    end

    pos_d  = pos_q;
    page_d = page_q;
    if (advance_i) begin
      if (pos_q == PosLast) begin
        pos_d  = '0;
        page_d = (page_q == PageLast) ? '0 : page_q + PW'(1);
      end else begin
        pos_d = pos_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      page_q <= '0;
    end else begin
      pos_q  <= pos_d;
      page_q <= page_d;
    end
  end

endmodule

### hdl/mono_frame_buffer_page_scanout_top.sv
// Top level of the page-mode monochrome frame buffer with byte scanout.
//
// The in_i channel carries one item per action: set point, clear point,
// clear all or refresh step. The out_o channel carries one scanout byte for
// each refresh step: per page the commands 0xB0+page, 0x00 and 0x10, then
// the COLUMNS column bytes as data, with frame_end on the last data byte of
// the last page. Other actions produce no output item.
// A set or clear point is a read of the frame store memory and then a write
// back of the modified byte. A refresh step that sends a command shows its
// byte in the cycle after the item is accepted; a data step waits on the
// registered memory read and then loads the output register. Clear all
// writes zeros over all COLUMNS*PAGES entries of the store (1024 with the
// default sizes), one entry a cycle; the scan position is kept.
// After reset the same clearing pass runs with in_i.ready low; the scan
// starts at page 0, step 0.
// The output byte sits in a register. While the receiver stalls, pixel
// actions are still accepted; a refresh step waits until the register frees.
module mono_frame_buffer_page_scanout_top #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mfbps_in_if.sink           in_i,
  mfbps_out_if.source        out_o
);

  localparam int Depth = COLUMNS * PAGES;
  localparam int AW    = $clog2(Depth);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int SW    = $clog2(COLUMNS + mfbps_pkg::HdrLen);
  localparam logic [AW-1:0] DepthLast = AW'(Depth - 1);

  mfbps_pkg::state_e  state_q, state_d;
  mfbps_pkg::action_e act;
  mfbps_pkg::scan_t   scan;

  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] addr_q, scan_addr, pix_addr, raddr, waddr;
  logic [7:0]    mask_q, rdata, wdata;
  logic          set_q, last_q;
  logic          we, advance, load_hdr, load_data, capture_pix, capture_last;
  logic          in_ready, accept, slot_free, in_range;
  logic [2:0]    pix_page;

  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q;
  logic          is_data_q, frame_end_q;

  mfbps_ram #(
    .Depth(Depth),
    .AW   (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  mfbps_scan #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES),
    .AW     (AW),
    .PW     (PW),
    .SW     (SW)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .scan_o   (scan),
    .addr_o   (scan_addr)
  );

  assign act       = mfbps_pkg::action_e'(in_i.action);
  assign pix_page  = in_i.y_pos[5:3];
  assign in_range  = (32'(in_i.x_pos) < COLUMNS) && (32'(pix_page) < PAGES);
  assign pix_addr  = AW'(32'(pix_page) * COLUMNS + 32'(in_i.x_pos));
  assign slot_free = !out_valid_q || out_o.ready;
  assign accept    = in_i.valid && in_ready;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    we           = 1'b0;
    waddr        = clr_q;
    wdata        = 8'h00;
    raddr        = scan_addr;
    advance      = 1'b0;
    in_ready     = 1'b0;
    load_hdr     = 1'b0;
    load_data    = 1'b0;
    capture_pix  = 1'b0;
    capture_last = 1'b0;
    unique case (state_q)
      mfbps_pkg::ST_CLEAR: begin
        we = 1'b1;
        if (clr_q == DepthLast) begin
          clr_d   = '0;
          state_d = mfbps_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      mfbps_pkg::ST_IDLE: begin
        in_ready = slot_free || (act != mfbps_pkg::ACT_REFRESH);
        if (accept) begin
          unique case (act)
            mfbps_pkg::ACT_SET_POINT, mfbps_pkg::ACT_CLEAR_POINT: begin
              if (in_range) begin
                raddr       = pix_addr;
                capture_pix = 1'b1;
                state_d     = mfbps_pkg::ST_RMW;
              end
            end
            mfbps_pkg::ACT_CLEAR_ALL: begin
              state_d = mfbps_pkg::ST_CLEAR;
            end
            mfbps_pkg::ACT_REFRESH: begin
              advance = 1'b1;
              if (scan.is_hdr) begin
                load_hdr = 1'b1;
              end else begin
                capture_last = 1'b1;
                state_d      = mfbps_pkg::ST_SCAN;
              end
            end
          endcase
        end
      end
      mfbps_pkg::ST_RMW: begin
        we      = 1'b1;
        waddr   = addr_q;
        wdata   = set_q ? (rdata | mask_q) : (rdata & ~mask_q);
        state_d = mfbps_pkg::ST_IDLE;
      end
      mfbps_pkg::ST_SCAN: begin
        load_data = 1'b1;
        state_d   = mfbps_pkg::ST_IDLE;
      end
      default: begin
        state_d = mfbps_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfbps_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_pix) begin
      addr_q <= pix_addr;
      mask_q <= 8'(1) << in_i.y_pos[2:0];
      set_q  <= (act == mfbps_pkg::ACT_SET_POINT);
    end
    if (capture_last) begin
      last_q <= scan.is_last;
    end
  end

  assign out_valid_d = (out_valid_q && !out_o.ready) || load_hdr || load_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_hdr) begin
      out_byte_q  <= scan.hdr_byte;
      is_data_q   <= 1'b0;
      frame_end_q <= 1'b0;
    end else if (load_data) begin
      out_byte_q  <= rdata;
      is_data_q   <= 1'b1;
      frame_end_q <= last_q;
    end
  end

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.is_data   = is_data_q;
  assign out_o.frame_end = frame_end_q;

endmodule

### hdl/mfbps_checker.sv
// Port-level checks of the frame buffer scanout and their binding to the top level.
module mfbps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_is_data_i,
  input logic       out_frame_end_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Output item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(out_is_data_i)
                                    && $stable(out_frame_end_i))
    else $error("Output item changed while stalled.");

  a_end_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_frame_end_i |-> out_is_data_i)
    else $error("Frame end marked on a command byte.");

  a_cmd_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_is_data_i |->
      (out_byte_i[7:4] == 4'hB) || (out_byte_i == 8'h00) || (out_byte_i == 8'h10))
    else $error("Command byte is not a page or column command.");

  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_i && !out_valid_i)
    else $error("Block ready before the clearing pass.");

endmodule

bind mono_frame_buffer_page_scanout_top mfbps_checker u_mfbps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .out_is_data_i  (out_o.is_data),
  .out_frame_end_i(out_o.frame_end)
);

### sim/tb.sv
// Self-checking testbench for the page-mode monochrome frame buffer scanout.
module tb;

  localparam int COLUMNS = 128;
  localparam int PAGES   = 8;

  typedef struct {
    mfbps_pkg::action_e act;
    logic [6:0]         x;
    logic [5:0]         y;
    bit                 drain;
  } pix_req_t;

  typedef struct {
    logic [7:0] scan_byte;
    logic       is_data;
    logic       frame_end;
  } scan_out_t;

  logic clk_i;
  logic rst_ni;

  mfbps_in_if  in_if ();
  mfbps_out_if out_if ();

  mono_frame_buffer_page_scanout_top #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  pix_req_t   item_q[$];
  scan_out_t  scan_expect_q[$];
  logic [7:0] model_store [COLUMNS*PAGES];
  int         model_page;
  int         model_pos;
  int         err_cnt;
  int         refresh_taken;
  int         bytes_seen;
  bit         gen_done;
  int         burst_left;
  int         gap_left;
  int         stall_mode;
  int         mode_left;
  pix_req_t   drv_req;

  task automatic report_mismatch(string msg);
    $display("ERROR t=%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic push_item(mfbps_pkg::action_e act, int x, int y, bit drain = 1'b0);
    pix_req_t r;
    r.act   = act;
    r.x     = x[6:0];
    r.y     = y[5:0];
    r.drain = drain;
    item_q.push_back(r);
  endtask

  task automatic predict_panel_step(pix_req_t r);
    int        idx;
    scan_out_t e;
    case (r.act)
      mfbps_pkg::ACT_SET_POINT, mfbps_pkg::ACT_CLEAR_POINT: begin
        if (int'(r.x) < COLUMNS && int'(r.y >> 3) < PAGES) begin
          idx = int'(r.y >> 3) * COLUMNS + int'(r.x);
          if (r.act == mfbps_pkg::ACT_SET_POINT) begin
            model_store[idx] = model_store[idx] | (8'd1 << r.y[2:0]);
          end else begin
            model_store[idx] = model_store[idx] & ~(8'd1 << r.y[2:0]);
          end
        end
      end
      mfbps_pkg::ACT_CLEAR_ALL: begin
        foreach (model_store[i]) model_store[i] = 8'd0;
      end
      default: begin
        if (model_page >= PAGES) model_page = 0;
        if (model_pos >= mfbps_pkg::HdrLen + COLUMNS) model_pos = 0;
        e.is_data   = 1'b0;
        e.frame_end = 1'b0;
        if (model_pos == 0) begin
          e.scan_byte = mfbps_pkg::CmdPageBase + 8'(model_page);
        end else if (model_pos == 1) begin
          e.scan_byte = mfbps_pkg::CmdColLow;
        end else if (model_pos == 2) begin
          e.scan_byte = mfbps_pkg::CmdColHigh;
        end else begin
          idx         = model_pos - mfbps_pkg::HdrLen;
          e.scan_byte = model_store[model_page * COLUMNS + idx];
          e.is_data   = 1'b1;
          e.frame_end = (idx == COLUMNS - 1) && (model_page == PAGES - 1);
        end
        scan_expect_q.push_back(e);
        model_pos++;
        if (model_pos >= mfbps_pkg::HdrLen + COLUMNS) begin
          model_pos = 0;
          model_page++;
          if (model_page >= PAGES) model_page = 0;
        end
      end
    endcase
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.action  = mfbps_pkg::ACT_REFRESH;
    in_if.x_pos   = '0;
    in_if.y_pos   = '0;
    out_if.ready  = 1'b0;
    foreach (model_store[i]) model_store[i] = 8'd0;
    model_page    = 0;
    model_pos     = 0;
    err_cnt       = 0;
    fork
      forever #10 clk_i = ~clk_i;
      begin
        repeat (4) @(posedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none
  end

  initial begin
    int r;
    int sx[$];
    int sy[$];
    int k;
    push_item(mfbps_pkg::ACT_SET_POINT, 0, 0);
    push_item(mfbps_pkg::ACT_SET_POINT, 127, 63);
    push_item(mfbps_pkg::ACT_SET_POINT, 1, 7);
    push_item(mfbps_pkg::ACT_SET_POINT, 1, 6);
    push_item(mfbps_pkg::ACT_CLEAR_POINT, 1, 7);
    push_item(mfbps_pkg::ACT_CLEAR_POINT, 2, 3);
    push_item(mfbps_pkg::ACT_SET_POINT, 2, 0);
    repeat (6) push_item(mfbps_pkg::ACT_REFRESH, 127, 63);
    push_item(mfbps_pkg::ACT_SET_POINT, 3, 2);
    push_item(mfbps_pkg::ACT_REFRESH, 0, 0);
    push_item(mfbps_pkg::ACT_CLEAR_ALL, 127, 63);
    push_item(mfbps_pkg::ACT_REFRESH, 0, 0);
    push_item(mfbps_pkg::ACT_SET_POINT, 5, 0);
    push_item(mfbps_pkg::ACT_REFRESH, 127, 63, 1'b1);
    push_item(mfbps_pkg::ACT_CLEAR_POINT, 127, 63);
    push_item(mfbps_pkg::ACT_CLEAR_POINT, 0, 0);
    for (int i = 0; i < 1680; i++) begin
      r = $urandom_range(0, 99);
      if (r == 0) begin
        push_item(mfbps_pkg::ACT_CLEAR_ALL, $urandom_range(0, 127), $urandom_range(0, 63));
      end else if (r <= 20) begin
        sx.push_back($urandom_range(0, 127));
        sy.push_back($urandom_range(0, 63));
        if (sx.size() > 32) begin
          void'(sx.pop_front());
          void'(sy.pop_front());
        end
        push_item(mfbps_pkg::ACT_SET_POINT, sx[$], sy[$]);
      end else if (r <= 27) begin
        if (sx.size() != 0 && $urandom_range(0, 1)) begin
          k = $urandom_range(0, sx.size() - 1);
          push_item(mfbps_pkg::ACT_CLEAR_POINT, sx[k], sy[k]);
        end else begin
          push_item(mfbps_pkg::ACT_CLEAR_POINT, $urandom_range(0, 127),
                    $urandom_range(0, 63));
        end
      end else begin
        push_item(mfbps_pkg::ACT_REFRESH, $urandom_range(0, 127), $urandom_range(0, 63),
                  (i % 400) == 200);
      end
    end
    gen_done = 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.action <= mfbps_pkg::ACT_REFRESH;
      in_if.x_pos  <= '0;
      in_if.y_pos  <= '0;
      burst_left   <= 1;
      gap_left     <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (item_q.size() != 0 &&
                   !(item_q[0].drain && (in_if.valid || refresh_taken != bytes_seen))) begin
        drv_req      = item_q.pop_front();
        in_if.valid  <= 1'b1;
        in_if.action <= drv_req.act;
        in_if.x_pos  <= drv_req.x;
        in_if.y_pos  <= drv_req.y;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_mode   <= 0;
      mode_left    <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(8, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= $urandom_range(0, 1);
        2:       out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= (mode_left % 4) != 3;
      endcase
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    scan_out_t e;
    pix_req_t  r;
    if (!rst_ni) begin
      refresh_taken <= 0;
      bytes_seen    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        bytes_seen <= bytes_seen + 1;
        if (scan_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %h", out_if.out_byte));
        end else begin
          e = scan_expect_q.pop_front();
          if (out_if.out_byte !== e.scan_byte)
            report_mismatch($sformatf("out_byte got %h want %h", out_if.out_byte, e.scan_byte));
          if (out_if.is_data !== e.is_data)
            report_mismatch($sformatf("is_data got %b want %b", out_if.is_data, e.is_data));
          if (out_if.frame_end !== e.frame_end)
            report_mismatch($sformatf("frame_end got %b want %b",
                                      out_if.frame_end, e.frame_end));
        end
      end
      if (in_if.valid && in_if.ready) begin
        r.act   = mfbps_pkg::action_e'(in_if.action);
        r.x     = in_if.x_pos;
        r.y     = in_if.y_pos;
        r.drain = 1'b0;
        if (r.act == mfbps_pkg::ACT_REFRESH) refresh_taken <= refresh_taken + 1;
        predict_panel_step(r);
      end
    end
  end

  initial begin
    @(posedge rst_ni);
    do @(negedge clk_i);
    while (!(gen_done && item_q.size() == 0 && !in_if.valid && scan_expect_q.size() == 0));
    repeat (20) @(negedge clk_i);
    if (err_cnt == 0 && scan_expect_q.size() == 0) begin
      $display("PASS mono_frame_buffer_page_scanout_top");
    end else begin
      $display("FAIL mono_frame_buffer_page_scanout_top");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("FAIL mono_frame_buffer_page_scanout_top");
    $finish;
  end

endmodule

### files.f
hdl/mfbps_pkg.sv
hdl/mfbps_in_if.sv
hdl/mfbps_out_if.sv
hdl/mfbps_ram.sv
hdl/mfbps_scan.sv
hdl/mono_frame_buffer_page_scanout_top.sv
hdl/mfbps_checker.sv
sim/tb.sv
